FILE: design/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Types, sequencer step codes and helper functions shared by the rate
// controller modules.
// ----------------------------------------------------------------------------
package prc_pkg;

	typedef logic signed [63:0] s64_t;

	// Event kinds as they arrive on the input channel.
	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_LOSS    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BOTTLENECK = 2'd0;
	localparam logic [1:0] CFG_BASE_RTT   = 2'd1;
	localparam logic [1:0] CFG_COALESCE   = 2'd2;
	localparam logic [1:0] CFG_RATE_FLOOR = 2'd3;

	localparam int QDEPTH = 2;

	// Sequencer steps of the back end.
	localparam logic [5:0] PC_IDLE = 6'd0;
	localparam logic [5:0] PC_R0  = 6'd1;
	localparam logic [5:0] PC_R1  = 6'd2;
	localparam logic [5:0] PC_R2  = 6'd3;
	localparam logic [5:0] PC_R3  = 6'd4;
	localparam logic [5:0] PC_R4  = 6'd5;
	localparam logic [5:0] PC_R5  = 6'd6;
	localparam logic [5:0] PC_R6  = 6'd7;
	localparam logic [5:0] PC_R7  = 6'd8;
	localparam logic [5:0] PC_A0  = 6'd9;
	localparam logic [5:0] PC_A1  = 6'd10;
	localparam logic [5:0] PC_A2  = 6'd11;
	localparam logic [5:0] PC_A3  = 6'd12;
	localparam logic [5:0] PC_A4  = 6'd13;
	localparam logic [5:0] PC_A5  = 6'd14;
	localparam logic [5:0] PC_A6  = 6'd15;
	localparam logic [5:0] PC_A7  = 6'd16;
	localparam logic [5:0] PC_A8  = 6'd17;
	localparam logic [5:0] PC_A9  = 6'd18;
	localparam logic [5:0] PC_A10 = 6'd19;
	localparam logic [5:0] PC_A11 = 6'd20;
	localparam logic [5:0] PC_A12 = 6'd21;
	localparam logic [5:0] PC_A13 = 6'd22;
	localparam logic [5:0] PC_L0  = 6'd23;
	localparam logic [5:0] PC_T0  = 6'd24;
	localparam logic [5:0] PC_T1  = 6'd25;
	localparam logic [5:0] PC_T2  = 6'd26;
	localparam logic [5:0] PC_T3  = 6'd27;
	localparam logic [5:0] PC_T4  = 6'd28;
	localparam logic [5:0] PC_T5  = 6'd29;
	localparam logic [5:0] PC_T6  = 6'd30;
	localparam logic [5:0] PC_T7  = 6'd31;
	localparam logic [5:0] PC_T8  = 6'd32;
	localparam logic [5:0] PC_T9  = 6'd33;
	localparam logic [5:0] PC_T10 = 6'd34;
	localparam logic [5:0] PC_Q0  = 6'd35;
	localparam logic [5:0] PC_Q1  = 6'd36;
	localparam logic [5:0] PC_Q2  = 6'd37;
	localparam logic [5:0] PC_Q3  = 6'd38;
	localparam logic [5:0] PC_Q4  = 6'd39;
	localparam logic [5:0] PC_Q5  = 6'd40;
	localparam logic [5:0] PC_Q6  = 6'd41;
	localparam logic [5:0] PC_Q7  = 6'd42;
	localparam logic [5:0] PC_Q8  = 6'd43;
	localparam logic [5:0] PC_Q9  = 6'd44;
	localparam logic [5:0] PC_Q10 = 6'd45;
	localparam logic [5:0] PC_Q11 = 6'd46;
	localparam logic [5:0] PC_W0  = 6'd47;
	localparam logic [5:0] PC_W1  = 6'd48;
	localparam logic [5:0] PC_W2  = 6'd49;
	localparam logic [5:0] PC_W3  = 6'd50;

	typedef struct packed {
		logic [39:0] bottleneck_rate;
		logic [23:0] base_rtt;
		logic [7:0]  coalesce;
		logic [19:0] rate_floor;
	} cfg_t;

	// One queued event: the first sequencer step and the event fields.
	typedef struct packed {
		logic [5:0]  entry;
		logic [47:0] now_us;
		logic [23:0] sample_rtt;
		logic [31:0] delivered_count;
		logic [15:0] seg_size;
		logic [7:0]  hop_count;
	} item_t;

	function automatic s64_t smin(input s64_t a, input s64_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic s64_t smax(input s64_t a, input s64_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic s64_t sclamp(input s64_t x, input s64_t lo, input s64_t hi);
		s64_t r;
		if (x < lo)
			r = lo;
		else if (x > hi)
			r = hi;
		else
			r = x;
		return r;
	endfunction

endpackage

FILE: design/prc_mul.sv
// ----------------------------------------------------------------------------
// prc_mul
// 64 x 64 multiplier giving the low 64 bits, built from one 32 x 32
// multiplier used over three partial products.
// ----------------------------------------------------------------------------
module prc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  prc_pkg::s64_t       a,
	input  prc_pkg::s64_t       b,
	output logic                done,
	output prc_pkg::s64_t       p
);
	import prc_pkg::*;

	logic [1:0]  step_q;
	logic [63:0] a_q, b_q, prod_q, acc_q, prod_c;
	logic [31:0] x, y;
	logic        done_q;

	always_comb begin
		case (step_q)
			2'd1: begin
				x = a_q[31:0];
				y = b_q[63:32];
			end
			2'd2: begin
				x = a_q[63:32];
				y = b_q[31:0];
			end
			default: begin
				x = a[31:0];
				y = b[31:0];
			end
		endcase
	end

	assign prod_c = x * y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			done_q <= 1'b0;
			a_q    <= '0;
			b_q    <= '0;
			prod_q <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				2'd0: begin
					if (start) begin
						a_q    <= a;
						b_q    <= b;
						prod_q <= prod_c;
						step_q <= 2'd1;
					end
				end
				2'd1: begin
					acc_q  <= prod_q;
					prod_q <= prod_c;
					step_q <= 2'd2;
				end
				2'd2: begin
					acc_q  <= acc_q + {prod_q[31:0], 32'b0};
					prod_q <= prod_c;
					step_q <= 2'd3;
				end
				default: begin
					acc_q  <= acc_q + {prod_q[31:0], 32'b0};
					done_q <= 1'b1;
					step_q <= 2'd0;
				end
			endcase
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

FILE: design/prc_div.sv
// ----------------------------------------------------------------------------
// prc_div
// Signed 64-bit divider, one quotient bit per cycle. The quotient is
// truncated toward zero and a zero divisor returns the dividend.
// ----------------------------------------------------------------------------
module prc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  prc_pkg::s64_t       x,
	input  prc_pkg::s64_t       y,
	output logic                done,
	output prc_pkg::s64_t       q
);
	import prc_pkg::*;

	logic        busy_q, neg_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q, dvs_q, q_q;
	logic [64:0] rem_q;
	logic [64:0] rem_sh, rem_n;
	logic [63:0] quo_n;
	logic        fits;

	assign rem_sh = {rem_q[63:0], quo_q[63]};
	assign fits   = rem_sh >= {1'b0, dvs_q};
	assign rem_n  = fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
	assign quo_n  = {quo_q[62:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (y == 64'sd0) begin
					q_q    <= x;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					neg_q  <= x[63] ^ y[63];
					quo_q  <= x[63] ? 64'(-x) : x;
					dvs_q  <= y[63] ? 64'(-y) : y;
					rem_q  <= '0;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					q_q    <= neg_q ? 64'(-quo_n) : quo_n;
				end
			end
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

FILE: design/prc_front.sv
// ----------------------------------------------------------------------------
// prc_front
// Accepts events, maps each kind to the first step of its update and holds
// them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module prc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [47:0]         now_us,
	input  logic [23:0]         sample_rtt,
	input  logic [31:0]         delivered_count,
	input  logic [15:0]         seg_size,
	input  logic [7:0]          hop_count,
	output logic                q_valid,
	output prc_pkg::item_t      q_item,
	input  logic                q_pop
);
	import prc_pkg::*;

	item_t      mem_q [QDEPTH];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       push, full;
	item_t      item_c;

	always_comb begin
		case (kind)
			KIND_ACK:     item_c.entry = PC_A0;
			KIND_LOSS:    item_c.entry = PC_L0;
			KIND_RESTART: item_c.entry = PC_R0;
			default:      item_c.entry = PC_W0;
		endcase
		item_c.now_us          = now_us;
		item_c.sample_rtt      = sample_rtt;
		item_c.delivered_count = delivered_count;
		item_c.seg_size        = seg_size;
		item_c.hop_count       = hop_count;
	end

	assign full     = cnt_q == 2'(QDEPTH);
	assign in_stall = full;
	assign push     = in_valid && !full;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= item_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

FILE: design/prc_back.sv
// ----------------------------------------------------------------------------
// prc_back
// Sequencer that carries out one event at a time on the controller state,
// using a shared multiplier and a shared divider, then forms the result.
// ----------------------------------------------------------------------------
module prc_back #(
	parameter int MICROS_PER_SEC = 1000000
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prc_pkg::cfg_t       cfg,
	input  logic                q_valid,
	input  prc_pkg::item_t      q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [40:0]         pacing_rate,
	output logic [31:0]         cwnd
);
	import prc_pkg::*;

	logic [5:0] pc_q;
	logic       wait_q;
	item_t      item_q;

	s64_t minr_q, srtt_q, srtt_ts_q, tc_q, tgt_q, rate_ts_q, tgt_ts_q;
	s64_t integ_q, drive_q, est_rate_q, est_del_q, est_ts_q;
	logic slow_q;
	s64_t t0_q, t1_q, t2_q, t3_q;

	logic        out_valid_q;
	logic [40:0] pacing_q;
	logic [31:0] cwnd_q;

	s64_t sb, sbase, scoal, sfloor, sm, snow, s_rtt, sdeliv, smss, shops;
	s64_t dt_s, dt_t, dt_r, dlv, est_lim, minr_new, tgt_new, top;
	s64_t op_a, op_b, res, mul_p, div_q;
	logic use_mul, use_div, mul_done, div_done, start, adv, running;

	assign sb     = {24'b0, cfg.bottleneck_rate};
	assign sbase  = {40'b0, cfg.base_rtt};
	assign scoal  = {56'b0, cfg.coalesce};
	assign sfloor = {44'b0, cfg.rate_floor};
	assign sm     = 64'(MICROS_PER_SEC);
	assign snow   = {16'b0, item_q.now_us};
	assign s_rtt  = {40'b0, item_q.sample_rtt};
	assign sdeliv = {32'b0, item_q.delivered_count};
	assign smss   = {48'b0, item_q.seg_size};
	assign shops  = {56'b0, item_q.hop_count};

	assign dt_s     = snow - srtt_ts_q;
	assign dt_t     = snow - tgt_ts_q;
	assign dt_r     = snow - rate_ts_q;
	assign dlv      = sdeliv - est_del_q;
	assign est_lim  = est_ts_q + tgt_q;
	assign minr_new = smax(sfloor, smin(sb >>> 7, t1_q));
	assign tgt_new  = (t1_q != 64'sd0) ? tgt_q + t1_q : tgt_q;
	assign top      = sb <<< 1;

	// Operand selection for the shared arithmetic units.
	always_comb begin
		use_mul = 1'b0;
		use_div = 1'b0;
		op_a    = t0_q;
		op_b    = t3_q;
		case (pc_q)
			PC_R0:  begin use_mul = 1'b1; op_a = smss; op_b = sm; end
			PC_R1:  begin use_div = 1'b1; op_b = sbase; end
			PC_R3:  begin use_div = 1'b1; op_b = sb; end
			PC_R5:  begin use_mul = 1'b1; op_a = shops; op_b = smss; end
			PC_R6:  begin use_div = 1'b1; op_b = minr_q; end
			PC_A0:  begin use_mul = 1'b1; op_a = smss; op_b = sm; end
			PC_A1:  begin use_div = 1'b1; op_b = srtt_q; end
			PC_A3:  begin use_div = 1'b1; op_b = sb; end
			PC_A6:  begin use_mul = 1'b1; end
			PC_A7:  begin use_div = 1'b1; op_b = sbase; end
			PC_A10: begin use_mul = 1'b1; op_b = smss; end
			PC_A11: begin use_mul = 1'b1; op_b = sm; end
			PC_A12: begin use_div = 1'b1; op_b = snow - est_ts_q; end
			PC_T1:  begin use_mul = 1'b1; op_a = scoal; op_b = smss; end
			PC_T2:  begin use_mul = 1'b1; op_b = sm; end
			PC_T3:  begin use_div = 1'b1; op_b = drive_q; end
			PC_T4:  begin use_mul = 1'b1; op_a = shops; op_b = smss; end
			PC_T5:  begin use_mul = 1'b1; op_b = sm; end
			PC_T6:  begin use_div = 1'b1; op_b = sb; end
			PC_T8:  begin use_mul = 1'b1; op_a = t2_q; end
			PC_T9:  begin use_div = 1'b1; op_b = tc_q; end
			PC_Q1:  begin use_mul = 1'b1; op_a = drive_q; end
			PC_Q2:  begin use_div = 1'b1; op_b = tc_q; end
			PC_Q3:  begin use_mul = 1'b1; op_a = est_rate_q; op_b = t2_q; end
			PC_Q4:  begin use_mul = 1'b1; end
			PC_Q5:  begin use_mul = 1'b1; op_a = tc_q; op_b = tc_q; end
			PC_Q6:  begin use_div = 1'b1; op_b = t1_q; end
			PC_Q8:  begin use_mul = 1'b1; op_a = est_rate_q <<< 1; op_b = t2_q; end
			PC_Q9:  begin use_div = 1'b1; op_b = tc_q; end
			PC_W0:  begin use_mul = 1'b1; op_a = sb; op_b = tgt_q; end
			PC_W1:  begin
				use_mul = 1'b1;
				op_a    = (item_q.seg_size == 16'd0) ? 64'sd1 : smss;
				op_b    = sm;
			end
			PC_W2:  begin use_div = 1'b1; op_b = t1_q; end
			default: begin end
		endcase
	end

	assign running = pc_q != PC_IDLE;
	assign start   = running && (use_mul || use_div) && !wait_q;
	assign res     = use_div ? div_q : mul_p;

	always_comb begin
		if (use_mul)
			adv = wait_q && mul_done;
		else if (use_div)
			adv = wait_q && div_done;
		else if (pc_q == PC_W3)
			adv = !out_valid_q || !out_stall;
		else
			adv = running;
	end

	assign q_pop = !running && q_valid;

	prc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && use_mul),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	prc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && use_div),
		.x      (op_a),
		.y      (op_b),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			wait_q      <= 1'b0;
			item_q      <= '0;
			minr_q      <= '0;
			srtt_q      <= '0;
			srtt_ts_q   <= '0;
			tc_q        <= '0;
			tgt_q       <= '0;
			rate_ts_q   <= '0;
			tgt_ts_q    <= '0;
			integ_q     <= '0;
			drive_q     <= '0;
			slow_q      <= 1'b1;
			est_rate_q  <= '0;
			est_del_q   <= '0;
			est_ts_q    <= '0;
			t0_q        <= '0;
			t1_q        <= '0;
			t2_q        <= '0;
			t3_q        <= '0;
			out_valid_q <= 1'b0;
			pacing_q    <= '0;
			cwnd_q      <= '0;
		end else begin
			// A word taken in the same cycle as a new one is formed is replaced below.
			if (out_valid_q && !out_stall && !(adv && pc_q == PC_W3))
				out_valid_q <= 1'b0;
			if (start)
				wait_q <= 1'b1;
			if (adv)
				wait_q <= 1'b0;
			if (!running) begin
				if (q_valid) begin
					item_q <= q_item;
					pc_q   <= q_item.entry;
				end
			end else if (adv) begin
				case (pc_q)
					// Restart: set the loop up from the configuration.
					PC_R0: begin t0_q <= res; pc_q <= PC_R1; end
					PC_R1: begin t1_q <= res; pc_q <= PC_R2; end
					PC_R2: begin
						minr_q     <= minr_new;
						srtt_q     <= s_rtt;
						srtt_ts_q  <= snow;
						rate_ts_q  <= snow;
						tgt_ts_q   <= snow;
						slow_q     <= 1'b1;
						est_rate_q <= sb;
						est_del_q  <= '0;
						est_ts_q   <= snow;
						pc_q       <= PC_R3;
					end
					PC_R3: begin t1_q <= res; pc_q <= PC_R4; end
					PC_R4: begin tc_q <= smax(sbase <<< 2, t1_q); pc_q <= PC_R5; end
					PC_R5: begin t0_q <= res; pc_q <= PC_R6; end
					PC_R6: begin t1_q <= res; pc_q <= PC_R7; end
					PC_R7: begin
						tgt_q   <= sbase + t1_q;
						integ_q <= minr_q;
						drive_q <= minr_q;
						pc_q    <= PC_W0;
					end
					// Ack: minimum rate, time constant, smoothed RTT, estimate.
					PC_A0: begin t0_q <= res; pc_q <= PC_A1; end
					PC_A1: begin t1_q <= res; pc_q <= PC_A2; end
					PC_A2: begin minr_q <= minr_new; pc_q <= PC_A3; end
					PC_A3: begin t1_q <= res; pc_q <= PC_A4; end
					PC_A4: begin tc_q <= smax(tgt_q <<< 2, t1_q); pc_q <= PC_A5; end
					PC_A5: begin
						if (dt_s < 64'sd1) begin
							pc_q <= PC_A9;
						end else begin
							t0_q <= s_rtt - srtt_q;
							t3_q <= smin(sbase, dt_s);
							pc_q <= PC_A6;
						end
					end
					PC_A6: begin t0_q <= res; pc_q <= PC_A7; end
					PC_A7: begin t1_q <= res; pc_q <= PC_A8; end
					PC_A8: begin
						if (t1_q != 64'sd0) begin
							srtt_ts_q <= snow;
							srtt_q    <= smax(sfloor, srtt_q + t1_q);
						end
						pc_q <= PC_A9;
					end
					PC_A9: begin
						if (snow > est_lim && dlv > 64'sd0) begin
							t0_q <= dlv;
							pc_q <= PC_A10;
						end else begin
							pc_q <= PC_T0;
						end
					end
					PC_A10: begin t0_q <= res; pc_q <= PC_A11; end
					PC_A11: begin t0_q <= res; pc_q <= PC_A12; end
					PC_A12: begin t1_q <= res; pc_q <= PC_A13; end
					PC_A13: begin
						est_rate_q <= sclamp((srtt_q > tgt_q) ? t1_q : smax(est_rate_q, t1_q),
							minr_q, top);
						est_del_q  <= sdeliv;
						est_ts_q   <= snow;
						pc_q       <= PC_T0;
					end
					PC_L0: begin slow_q <= 1'b0; pc_q <= PC_T0; end
					// Target delay update.
					PC_T0: begin
						if (dt_t < 64'sd1) begin
							pc_q <= PC_Q0;
						end else begin
							t3_q <= dt_t;
							pc_q <= PC_T1;
						end
					end
					PC_T1: begin t0_q <= res; pc_q <= PC_T2; end
					PC_T2: begin t0_q <= res; pc_q <= PC_T3; end
					PC_T3: begin t1_q <= res; pc_q <= PC_T4; end
					PC_T4: begin t0_q <= res; t2_q <= sbase + t1_q; pc_q <= PC_T5; end
					PC_T5: begin t0_q <= res; pc_q <= PC_T6; end
					PC_T6: begin t1_q <= res; pc_q <= PC_T7; end
					PC_T7: begin
						t2_q <= t2_q + t1_q - tgt_q;
						t3_q <= smin(tc_q, t3_q);
						pc_q <= PC_T8;
					end
					PC_T8: begin t0_q <= res; pc_q <= PC_T9; end
					PC_T9: begin t1_q <= res; pc_q <= PC_T10; end
					PC_T10: begin
						if (t1_q != 64'sd0)
							tgt_ts_q <= snow;
						tgt_q <= smax(sbase, tgt_new);
						pc_q  <= PC_Q0;
					end
					// Pacing rate update.
					PC_Q0: begin
						if (dt_r < 64'sd1) begin
							pc_q <= PC_W0;
						end else begin
							t3_q <= smin(tc_q, dt_r);
							t2_q <= tgt_q - s_rtt;
							pc_q <= slow_q ? PC_Q1 : PC_Q3;
						end
					end
					PC_Q1: begin t0_q <= res; pc_q <= PC_Q2; end
					PC_Q2: begin t1_q <= res; pc_q <= PC_Q7; end
					PC_Q3: begin t0_q <= res; pc_q <= PC_Q4; end
					PC_Q4: begin t0_q <= res; pc_q <= PC_Q5; end
					PC_Q5: begin t1_q <= res; pc_q <= PC_Q6; end
					PC_Q6: begin t1_q <= res; pc_q <= PC_Q7; end
					PC_Q7: begin
						if (t1_q != 64'sd0) begin
							rate_ts_q <= snow;
							integ_q   <= integ_q + t1_q;
							pc_q      <= PC_Q8;
						end else begin
							pc_q <= PC_Q11;
						end
					end
					PC_Q8:  begin t0_q <= res; pc_q <= PC_Q9; end
					PC_Q9:  begin t1_q <= res; pc_q <= PC_Q10; end
					PC_Q10: begin drive_q <= t1_q + integ_q; pc_q <= PC_Q11; end
					PC_Q11: begin
						integ_q <= sclamp(integ_q, minr_q, top);
						drive_q <= sclamp(drive_q, minr_q, top);
						pc_q    <= PC_W0;
					end
					// Window and result.
					PC_W0: begin t0_q <= res; pc_q <= PC_W1; end
					PC_W1: begin t1_q <= res; pc_q <= PC_W2; end
					PC_W2: begin t1_q <= res; pc_q <= PC_W3; end
					PC_W3: begin
						if (t1_q < 64'sd4)
							cwnd_q <= 32'd4;
						else if (t1_q > 64'sh0000_0000_FFFF_FFFF)
							cwnd_q <= 32'hFFFF_FFFF;
						else
							cwnd_q <= t1_q[31:0];
						pacing_q    <= drive_q[40:0];
						out_valid_q <= 1'b1;
						pc_q        <= PC_IDLE;
					end
					default: pc_q <= PC_IDLE;
				endcase
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pacing_rate = pacing_q;
	assign cwnd        = cwnd_q;

endmodule

FILE: design/pid_rate_congestion_controller.sv
// ----------------------------------------------------------------------------
// pid_rate_congestion_controller
// Delay-based PI rate controller: one ack, loss or restart event in, one
// pacing rate and congestion window out.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the in_valid / in_stall channel; a word is taken on a
// clock edge with in_valid high and in_stall low. A two-entry queue sits
// in front of the sequencer, so in_stall rises only when both entries hold.
// Each event yields one result word on out_valid / out_stall, held until
// taken. A full output register does not stop the queue from filling.
// Events are processed one at a time: the sequencer takes no new event from
// the queue until the current one has formed its result word. How long an
// event takes is set by the shared divider and the shared multiplier; the
// steps skipped for zero elapsed time shorten it. Configuration is written
// through cfg_we / cfg_index / cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce. Reset clears
// the loop state to zero, sets slow start and loads the configuration
// defaults; no result is pending after it.
// ----------------------------------------------------------------------------
module pid_rate_congestion_controller #(
	parameter int MICROS_PER_SEC = 1000000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [47:0] now_us,
	input  logic [23:0] sample_rtt,
	input  logic [31:0] delivered_count,
	input  logic [15:0] seg_size,
	input  logic [7:0]  hop_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [40:0] pacing_rate,
	output logic [31:0] cwnd
);
	import prc_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid, q_pop;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bottleneck_rate <= 40'd125000000;
			cfg_q.base_rtt        <= 24'd100;
			cfg_q.coalesce        <= 8'd1;
			cfg_q.rate_floor      <= 20'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOTTLENECK: cfg_q.bottleneck_rate <= cfg_data;
				CFG_BASE_RTT:   cfg_q.base_rtt        <= cfg_data[23:0];
				CFG_COALESCE:   cfg_q.coalesce        <= cfg_data[7:0];
				CFG_RATE_FLOOR: cfg_q.rate_floor      <= cfg_data[19:0];
				default: begin end
			endcase
		end
	end

	prc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.now_us          (now_us),
		.sample_rtt      (sample_rtt),
		.delivered_count (delivered_count),
		.seg_size        (seg_size),
		.hop_count       (hop_count),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop)
	);

	prc_back #(
		.MICROS_PER_SEC (MICROS_PER_SEC)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pacing_rate (pacing_rate),
		.cwnd        (cwnd)
	);

endmodule

FILE: tb/tb_pid_rate_congestion_controller.sv
// ----------------------------------------------------------------------------
// tb_pid_rate_congestion_controller
// Self-checking bench for the PI rate controller. Event words are driven
// with random gaps, results are taken with random stalls, and each result
// is compared with a bit-exact software copy of the control loop.
// ----------------------------------------------------------------------------
module tb_pid_rate_congestion_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import prc_pkg::*;

	localparam longint USEC = 1000000;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic [47:0] now_us;
		logic [23:0] sample_rtt;
		logic [31:0] delivered_count;
		logic [15:0] seg_size;
		logic [7:0]  hop_count;
	} event_t;

	typedef struct {
		logic [40:0] rate;
		logic [31:0] win;
	} pacing_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = CFG_BOTTLENECK;
	logic [39:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  kind = KIND_ACK;
	logic [47:0] now_us = '0;
	logic [23:0] sample_rtt = '0;
	logic [31:0] delivered_count = '0;
	logic [15:0] seg_size = '0;
	logic [7:0]  hop_count = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [40:0] pacing_rate;
	logic [31:0] cwnd;

	pid_rate_congestion_controller i_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Configuration copy.
	longint c_bneck, c_base, c_coal, c_floor;
	// Loop state copy.
	longint m_minr, m_srtt, m_srtt_ts, m_tau, m_tgt, m_rate_ts, m_tgt_ts;
	longint m_integ, m_drive, m_est, m_est_deliv, m_est_ts;
	bit     m_slow;

	pacing_t expected_q[$];
	int      errors = 0;
	bit      send_gaps = 1;
	bit      take_gaps = 1;
	int      hold_off = 0;
	longint  clock_us = 0;

	function automatic longint qdiv(longint x, longint y);
		if (y == 0)
			return x;
		if (y == -1)
			return 0 - x;
		return x / y;
	endfunction

	function automatic longint lesser(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint greater(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint bound(longint x, longint lo, longint hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	function automatic void calc_min_rate(longint mss, longint rtt);
		m_minr = greater(c_floor, lesser(c_bneck / 128, qdiv(mss * USEC, rtt)));
	endfunction

	function automatic void advance_srtt(longint t, longint rtt);
		longint dt, d;
		dt = t - m_srtt_ts;
		if (dt < 1)
			return;
		d = qdiv((rtt - m_srtt) * lesser(c_base, dt), c_base);
		if (d != 0) begin
			m_srtt_ts = t;
			m_srtt = greater(c_floor, m_srtt + d);
		end
	endfunction

	function automatic void advance_target(longint t, longint mss, longint hops);
		longint dt, nt, d;
		dt = t - m_tgt_ts;
		if (dt < 1)
			return;
		nt = c_base + qdiv(c_coal * mss * USEC, m_drive)
			+ qdiv(hops * mss * USEC, c_bneck);
		d = qdiv((nt - m_tgt) * lesser(m_tau, dt), m_tau);
		if (d != 0) begin
			m_tgt_ts = t;
			m_tgt = m_tgt + d;
		end
		m_tgt = greater(c_base, m_tgt);
	endfunction

	function automatic void advance_rate(longint t, longint rtt);
		longint dt, err, d, top;
		dt = t - m_rate_ts;
		if (dt < 1)
			return;
		err = m_tgt - rtt;
		if (m_slow)
			d = qdiv(m_drive * lesser(m_tau, dt), m_tau);
		else
			d = qdiv(m_est * err * lesser(m_tau, dt), m_tau * m_tau);
		if (d != 0) begin
			m_rate_ts = t;
			m_integ = m_integ + d;
			m_drive = qdiv(2 * m_est * err, m_tau) + m_integ;
		end
		top = 2 * c_bneck;
		m_integ = bound(m_integ, m_minr, top);
		m_drive = bound(m_drive, m_minr, top);
	endfunction

	function automatic void loop_reset();
		m_minr = 0; m_srtt = 0; m_srtt_ts = 0; m_tau = 0; m_tgt = 0;
		m_rate_ts = 0; m_tgt_ts = 0; m_integ = 0; m_drive = 0; m_slow = 1;
		m_est = 0; m_est_deliv = 0; m_est_ts = 0;
		c_bneck = 125000000; c_base = 100; c_coal = 1; c_floor = 1;
	endfunction

	function automatic pacing_t predict_pacing(event_t e);
		longint t, rtt, dl, mss, hops, deliv, est, num, bdp;
		pacing_t r;
		t = longint'(e.now_us);
		rtt = longint'(e.sample_rtt);
		dl = longint'(e.delivered_count);
		mss = longint'(e.seg_size);
		hops = longint'(e.hop_count);
		case (e.kind)
			KIND_ACK: begin
				calc_min_rate(mss, m_srtt);
				m_tau = greater(4 * m_tgt, qdiv(mss * USEC, c_bneck));
				advance_srtt(t, rtt);
				deliv = dl - m_est_deliv;
				if (t > m_est_ts + m_tgt && deliv > 0) begin
					est = qdiv(deliv * mss * USEC, t - m_est_ts);
					if (m_srtt > m_tgt)
						m_est = est;
					else
						m_est = greater(m_est, est);
					m_est = bound(m_est, m_minr, 2 * c_bneck);
					m_est_deliv = dl;
					m_est_ts = t;
				end
				advance_target(t, mss, hops);
				advance_rate(t, rtt);
			end
			KIND_LOSS: begin
				m_slow = 0;
				advance_target(t, mss, hops);
				advance_rate(t, rtt);
			end
			KIND_RESTART: begin
				calc_min_rate(mss, c_base);
				m_srtt = rtt;
				m_srtt_ts = t;
				m_tau = greater(4 * c_base, qdiv(mss * USEC, c_bneck));
				m_tgt = c_base + qdiv(hops * mss, m_minr);
				m_rate_ts = t;
				m_tgt_ts = t;
				m_integ = m_minr;
				m_drive = m_minr;
				m_slow = 1;
				m_est = c_bneck;
				m_est_deliv = 0;
				m_est_ts = t;
			end
			default: ;
		endcase
		num = c_bneck * m_tgt;
		if (mss < 1)
			bdp = qdiv(num, USEC);
		else
			bdp = qdiv(num, mss * USEC);
		bdp = greater(4, bdp);
		if (bdp > 64'hFFFF_FFFF)
			bdp = 64'hFFFF_FFFF;
		r.rate = m_drive[40:0];
		r.win = bdp[31:0];
		return r;
	endfunction

	// Result side: random stall before each word, plus an optional long hold-off.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				n = hold_off;
				hold_off = 0;
				out_stall = 1;
				repeat (n) @(negedge clk);
			end
			n = take_gaps ? $urandom_range(0, 6) : 0;
			if (n > 0) begin
				out_stall = 1;
				repeat (n) @(negedge clk);
			end
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		pacing_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: rate %0d cwnd %0d",
					pacing_rate, cwnd);
				errors++;
			end else begin
				x = expected_q.pop_front();
				if (pacing_rate !== x.rate) begin
					$error("pacing_rate expected %0d actual %0d", x.rate, pacing_rate);
					errors++;
				end
				if (cwnd !== x.win) begin
					$error("cwnd expected %0d actual %0d", x.win, cwnd);
					errors++;
				end
			end
		end
	end

	task automatic send_event(event_t e);
		int gap;
		gap = send_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		kind = e.kind;
		now_us = e.now_us;
		sample_rtt = e.sample_rtt;
		delivered_count = e.delivered_count;
		seg_size = e.seg_size;
		hop_count = e.hop_count;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(predict_pacing(e));
		@(negedge clk);
	endtask

	task automatic send_fields(logic [1:0] k, logic [47:0] t, logic [23:0] rtt,
			logic [31:0] dl, logic [15:0] mss, logic [7:0] hops);
		event_t e;
		e.kind = k; e.now_us = t; e.sample_rtt = rtt;
		e.delivered_count = dl; e.seg_size = mss; e.hop_count = hops;
		send_event(e);
	endtask

	task automatic drain();
		in_valid = 0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			CFG_BOTTLENECK: c_bneck = longint'(val);
			CFG_BASE_RTT:   c_base = longint'(val[23:0]);
			CFG_COALESCE:   c_coal = longint'(val[7:0]);
			default:        c_floor = longint'(val[19:0]);
		endcase
	endtask

	function automatic event_t noise_event();
		event_t e;
		e.kind = 2'($urandom_range(0, 3));
		e.now_us = 48'({$urandom(), $urandom()});
		e.sample_rtt = 24'($urandom());
		e.delivered_count = $urandom();
		e.seg_size = 16'($urandom());
		e.hop_count = 8'($urandom());
		return e;
	endfunction

	// A restart followed by a plausible flow: time moves forward, RTT stays
	// near the base RTT, and the delivered count grows. A few noisy words
	// are mixed in.
	task automatic run_flow(int count);
		event_t e;
		logic [31:0] dl;
		logic [15:0] mss;
		int r;
		dl = 0;
		mss = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'd1460;
		clock_us += longint'($urandom_range(1, 100000));
		send_fields(KIND_RESTART, clock_us[47:0], 24'(c_base + $urandom_range(0, 50)),
			32'd0, mss, 8'($urandom_range(1, 30)));
		for (int i = 1; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send_event(noise_event());
			end else begin
				clock_us += longint'($urandom_range(0,
					int'(3 * lesser(c_base, 2000) + 10)));
				dl += 32'($urandom_range(0, 60));
				e.kind = (r < 85) ? KIND_ACK : (r < 97) ? KIND_LOSS : KIND_RESTART;
				e.now_us = clock_us[47:0];
				e.sample_rtt = 24'(c_base + $urandom_range(0, int'(2 * lesser(c_base, 5000))));
				e.delivered_count = dl;
				e.seg_size = mss;
				e.hop_count = 8'($urandom_range(1, 40));
				send_event(e);
			end
		end
	endtask

	task automatic test_before_restart();
		send_fields(KIND_ACK, 48'd1000, 24'd80, 32'd10, 16'd1460, 8'd5);
		send_fields(KIND_LOSS, 48'd2000, 24'd90, 32'd20, 16'd0, 8'd0);
		send_fields(KIND_SPARE, 48'd3000, 24'd70, 32'd30, 16'd536, 8'd3);
		send_fields(KIND_ACK, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 8'hFF);
		drain();
	endtask

	task automatic test_directed();
		send_fields(KIND_RESTART, 48'd10000, 24'd120, 32'd0, 16'd1460, 8'd10);
		send_fields(KIND_ACK, 48'd10000, 24'd120, 32'd5, 16'd1460, 8'd10);
		send_fields(KIND_ACK, 48'd10500, 24'd130, 32'd50, 16'd1460, 8'd10);
		send_fields(KIND_ACK, 48'd11500, 24'd200, 32'd150, 16'd1460, 8'd10);
		send_fields(KIND_LOSS, 48'd12000, 24'd400, 32'd160, 16'd1460, 8'd10);
		send_fields(KIND_ACK, 48'd13000, 24'd0, 32'd300, 16'd1460, 8'd10);
		send_fields(KIND_SPARE, 48'd13500, 24'd100, 32'd310, 16'd1460, 8'd10);
		send_fields(KIND_ACK, 48'd14000, 24'hFF_FFFF, 32'd400, 16'd0, 8'd0);
		send_fields(KIND_ACK, 48'd13000, 24'd100, 32'd100, 16'd1460, 8'd10);
		send_fields(KIND_RESTART, 48'd0, 24'd0, 32'd0, 16'd0, 8'd0);
		send_fields(KIND_ACK, 48'd5, 24'd1, 32'd1, 16'd0, 8'd0);
		send_fields(KIND_RESTART, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 8'hFF);
		send_fields(KIND_ACK, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 8'hFF);
		send_fields(KIND_LOSS, 48'd0, 24'hFF_FFFF, 32'd0, 16'hFFFF, 8'hFF);
		send_fields(KIND_ACK, 48'd100, 24'd0, 32'hFFFF_FFFF, 16'd1, 8'd1);
		drain();
	endtask

	task automatic test_config_sweep();
		write_reg(CFG_BOTTLENECK, 40'hFF_FFFF_FFFF);
		write_reg(CFG_BASE_RTT, 40'hFF_FFFF);
		write_reg(CFG_COALESCE, 40'd255);
		write_reg(CFG_RATE_FLOOR, 40'hF_FFFF);
		run_flow(60);
		drain();
		write_reg(CFG_BOTTLENECK, 40'd1);
		write_reg(CFG_BASE_RTT, 40'd1);
		write_reg(CFG_COALESCE, 40'd0);
		write_reg(CFG_RATE_FLOOR, 40'd1);
		run_flow(60);
		drain();
		for (int k = 0; k < 4; k++) begin
			write_reg(CFG_BOTTLENECK, 40'($urandom_range(1000000, 2000000000)));
			write_reg(CFG_BASE_RTT, 40'($urandom_range(10, 20000)));
			write_reg(CFG_COALESCE, 40'($urandom_range(0, 255)));
			write_reg(CFG_RATE_FLOOR, 40'($urandom_range(1, 5000)));
			send_gaps = k[0];
			take_gaps = k[1];
			run_flow(110);
			drain();
		end
		send_gaps = 1;
		take_gaps = 1;
	endtask

	task automatic test_backpressure();
		write_reg(CFG_BOTTLENECK, 40'd125000000);
		write_reg(CFG_BASE_RTT, 40'd100);
		write_reg(CFG_COALESCE, 40'd1);
		write_reg(CFG_RATE_FLOOR, 40'd1);
		hold_off = 4000;
		send_gaps = 0;
		run_flow(40);
		send_gaps = 1;
		drain();
	endtask

	task automatic test_random();
		for (int k = 0; k < 12; k++)
			run_flow($urandom_range(40, 90));
		drain();
	endtask

	initial begin
		loop_reset();
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_before_restart();
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("PASS pid_rate_congestion_controller");
		else
			$display("FAIL pid_rate_congestion_controller");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("FAIL pid_rate_congestion_controller");
		$finish;
	end

endmodule
